// ===== rtl/vra_pkg.sv =====
// ----------------------------------------------------------------------------
// vra_pkg
// Shared types and constants for the value rank assigner.
// ----------------------------------------------------------------------------
`default_nettype none

package vra_pkg;

    localparam int RANK_W  = 7;
    localparam int VALUE_W = 32;

    typedef struct packed {
        logic wr_en;        // store incoming value or flag overflow
        logic set_clr;      // clear item count and overflow flag
        logic k_clr;        // restart result index
        logic k_inc;        // next result index
        logic key_rd;       // read entry at result index
        logic sweep_start;  // latch key, restart sweep and rank
        logic sweep_en;     // step the compare sweep
        logic load_out;     // load output registers
    } vra_cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic out_last;
    } vra_sts_t;

endpackage

`default_nettype wire

// ===== rtl/vra_ctrl.sv =====
// ----------------------------------------------------------------------------
// vra_ctrl
// Controller: load phase, then per-result key read, compare sweep and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module vra_ctrl
    import vra_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     is_last,
    input  wire logic     out_stall,
    input  wire vra_sts_t sts,
    output vra_cmd_t      cmd,
    output logic          in_stall,
    output logic          out_valid
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_KEY   = 3'd1;
    localparam logic [2:0] ST_KEYW  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall  = (state_reg != ST_LOAD);
    assign out_valid = (state_reg == ST_EMIT);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.wr_en = 1'b1;
                    if (is_last)
                    begin
                        cmd.k_clr  = 1'b1;
                        state_next = ST_KEY;
                    end
                end
            end
            ST_KEY:
            begin
                cmd.key_rd = 1'b1;
                state_next = ST_KEYW;
            end
            ST_KEYW:
            begin
                cmd.sweep_start = 1'b1;
                state_next      = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                cmd.sweep_en = 1'b1;
                if (sts.sweep_done)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    if (sts.out_last)
                    begin
                        cmd.set_clr = 1'b1;
                        state_next  = ST_LOAD;
                    end
                    else
                    begin
                        cmd.k_inc  = 1'b1;
                        state_next = ST_KEY;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/vra_datapath.sv =====
// ----------------------------------------------------------------------------
// vra_datapath
// Value store, item count, single comparator sweep and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module vra_datapath
    import vra_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire vra_cmd_t                  cmd,
    input  wire logic signed [VALUE_W-1:0] value,
    output vra_sts_t                       sts,
    output logic [RANK_W-1:0]              rank,
    output logic                           last_rank,
    output logic                           overflowed
);

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    logic signed [VALUE_W-1:0] store_mem [MAX_ITEMS];

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      overflow_reg;
    logic                      overflow_next;
    logic [IW-1:0]             k_reg;
    logic [IW-1:0]             k_next;
    logic [CW-1:0]             j_reg;
    logic [CW-1:0]             j_next;
    logic                      pend_reg;
    logic                      pend_next;
    logic [IW-1:0]             pend_idx_reg;
    logic signed [VALUE_W-1:0] key_reg;
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic [RANK_W-1:0]         rank_acc_reg;
    logic [RANK_W-1:0]         rank_acc_next;
    logic [RANK_W-1:0]         rank_reg;
    logic                      last_rank_reg;
    logic                      overflowed_reg;

    logic                      full;
    logic                      issue;
    logic                      hit;
    logic [IW-1:0]             rd_addr;

    assign full    = (count_reg == CW'(MAX_ITEMS));
    assign issue   = cmd.sweep_en && (j_reg != count_reg);
    assign rd_addr = cmd.key_rd ? k_reg : j_reg[IW-1:0];
    // smaller, or equal and loaded earlier
    assign hit     = pend_reg && ((rd_data_reg < key_reg) ||
                     ((rd_data_reg == key_reg) && (pend_idx_reg < k_reg)));

    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        if (cmd.set_clr)
        begin
            count_next    = '0;
            overflow_next = 1'b0;
        end
        else if (cmd.wr_en)
        begin
            if (full)
            begin
                overflow_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        k_next = k_reg;
        if (cmd.k_clr)
        begin
            k_next = '0;
        end
        else if (cmd.k_inc)
        begin
            k_next = k_reg + IW'(1);
        end
    end

    always_comb
    begin
        j_next        = j_reg;
        pend_next     = pend_reg;
        rank_acc_next = rank_acc_reg;
        if (cmd.sweep_start)
        begin
            j_next        = '0;
            pend_next     = 1'b0;
            rank_acc_next = RANK_W'(1);
        end
        else if (cmd.sweep_en)
        begin
            pend_next = issue;
            if (issue)
            begin
                j_next = j_reg + CW'(1);
            end
            if (hit)
            begin
                rank_acc_next = rank_acc_reg + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            k_reg        <= '0;
            j_reg        <= '0;
            pend_reg     <= 1'b0;
            rank_acc_reg <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            k_reg        <= k_next;
            j_reg        <= j_next;
            pend_reg     <= pend_next;
            rank_acc_reg <= rank_acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && !full)
        begin
            store_mem[count_reg[IW-1:0]] <= value;
        end
        if (cmd.key_rd || issue)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_idx_reg <= j_reg[IW-1:0];
        end
        if (cmd.sweep_start)
        begin
            key_reg <= rd_data_reg;
        end
        if (cmd.load_out)
        begin
            rank_reg       <= rank_acc_reg;
            last_rank_reg  <= ((CW'(k_reg) + CW'(1)) == count_reg);
            overflowed_reg <= overflow_reg;
        end
    end

    assign sts.sweep_done = (j_reg == count_reg) && !pend_reg;
    assign sts.out_last   = last_rank_reg;
    assign rank           = rank_reg;
    assign last_rank      = last_rank_reg;
    assign overflowed     = overflowed_reg;

endmodule

`default_nettype wire

// ===== rtl/value_rank_assigner_unit.sv =====
// ----------------------------------------------------------------------------
// value_rank_assigner_unit
// Loads a set of signed values, then emits each value's ascending rank in
// load order.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------
//   input    | in        | in_valid / in_stall | value, is_last
//   output   | out       | out_valid/out_stall | rank, last_rank, overflowed
//
// Loading accepts one request per cycle; in_stall is low only while loading.
// After the last request, each rank is made in turn by a key read, a key
// latch, a sweep through the single comparator and an emit, all bound by
// the one read port of the value store; a stalled output extends the emit state.
// Reset clears the controller, item count and overflow flag; no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module value_rank_assigner_unit
    import vra_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic                      is_last,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [RANK_W-1:0]              rank,
    output logic                           last_rank,
    output logic                           overflowed
);

    vra_cmd_t cmd;
    vra_sts_t sts;

    vra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .is_last   (is_last),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    vra_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .value      (value),
        .sts        (sts),
        .rank       (rank),
        .last_rank  (last_rank),
        .overflowed (overflowed)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("output request while input open");

    a_last_starts_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && is_last) |=> in_stall)
        else $error("input not closed after last request");

    a_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((rank != '0) && (rank <= RANK_W'(MAX_ITEMS))))
        else $error("rank out of range");

    a_reopen_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last_rank) |=> !in_stall)
        else $error("input not reopened after final rank");
`endif

endmodule

`default_nettype wire

// ===== sim/vra_rank_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_rank_checker
// Watches both channels of the value rank assigner. It keeps its own copy of
// the loaded set, works out the rank of every stored value when the closing
// request arrives, and compares each output request field by field with
// the oldest expected rank.
// ----------------------------------------------------------------------------
`default_nettype none

module vra_rank_checker
    import vra_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic                      in_stall,
    input  wire logic signed [VALUE_W-1:0] value,
    input  wire logic                      is_last,
    input  wire logic                      out_valid,
    input  wire logic                      out_stall,
    input  wire logic [RANK_W-1:0]         rank,
    input  wire logic                      last_rank,
    input  wire logic                      overflowed,
    output int                             fail_count,
    output int                             pending,
    output int                             ranks_checked
);

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              last_rank;
        logic              overflowed;
    } rank_result_t;

    rank_result_t             expected_ranks[$];
    logic signed [VALUE_W-1:0] loaded_values[MAX_ITEMS];
    int unsigned               loaded_count;
    logic                      overflow_flag;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic logic [RANK_W-1:0] rank_at(input int unsigned k);
        int unsigned r;
        r = 1;
        for (int unsigned j = 0; j < loaded_count; j++)
        begin
            if (loaded_values[j] < loaded_values[k])
                r++;
            else if (loaded_values[j] == loaded_values[k] && j < k)
                r++;
        end
        return r[RANK_W-1:0];
    endfunction

    task automatic take_request(input logic signed [VALUE_W-1:0] v, input logic last);
        rank_result_t want;
        if (loaded_count < MAX_ITEMS)
        begin
            loaded_values[loaded_count] = v;
            loaded_count++;
        end
        else
            overflow_flag = 1'b1;
        if (last)
        begin
            for (int unsigned k = 0; k < loaded_count; k++)
            begin
                want.rank       = rank_at(k);
                want.last_rank  = (k + 1 == loaded_count);
                want.overflowed = overflow_flag;
                expected_ranks.push_back(want);
            end
            loaded_count  = 0;
            overflow_flag = 1'b0;
        end
    endtask

    task automatic check_result();
        rank_result_t want;
        ranks_checked++;
        if (expected_ranks.size() == 0)
        begin
            report_mismatch($sformatf("rank %0d arrived with none expected", rank));
            return;
        end
        want = expected_ranks.pop_front();
        if (rank !== want.rank)
            report_mismatch($sformatf("rank got %0d expected %0d", rank, want.rank));
        if (last_rank !== want.last_rank)
            report_mismatch($sformatf("last_rank got %b expected %b",
                                      last_rank, want.last_rank));
        if (overflowed !== want.overflowed)
            report_mismatch($sformatf("overflowed got %b expected %b",
                                      overflowed, want.overflowed));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_count  = 0;
            overflow_flag = 1'b0;
            expected_ranks.delete();
            pending       = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                take_request(value, is_last);
            if (out_valid && !out_stall)
                check_result();
            pending = expected_ranks.size();
        end
    end

endmodule

`default_nettype wire

// ===== sim/value_rank_assigner_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_rank_assigner_unit_tb
// Drives sets of signed values into the value rank assigner: a few directed
// sets with 32-bit extremes and ties, then random sets of mixed sizes, some
// full and some beyond the store, under four idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module value_rank_assigner_unit_tb
    import vra_pkg::*;
();

    localparam int MAX_ITEMS       = 64;
    localparam int RANDOM_REQUESTS = 415;
    localparam int IDLE_LIMIT      = 5000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int DIRECTED_COUNT  = 15;

    localparam logic signed [VALUE_W-1:0] DIRECTED_VALUES[DIRECTED_COUNT] = '{
        32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, 32'shffff_ffff, 32'sd1,
        32'sd42,
        32'sd7, 32'sd7, -32'sd7, 32'sd7, -32'sd7,
        32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000
    };
    localparam logic [DIRECTED_COUNT-1:0] DIRECTED_ENDS = 15'h4430;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [VALUE_W-1:0] value;
    logic                      is_last;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [RANK_W-1:0]         rank;
    logic                      last_rank;
    logic                      overflowed;

    int   fail_count;
    int   pending;
    int   ranks_checked;
    logic in_fire = 1'b0;
    int   idle_cycles = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   requests_sent = 0;
    int   sets_sent = 0;
    int   overflow_sets = 0;

    value_rank_assigner_unit #(
        .MAX_ITEMS (MAX_ITEMS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (value),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rank       (rank),
        .last_rank  (last_rank),
        .overflowed (overflowed)
    );

    vra_rank_checker #(
        .MAX_ITEMS (MAX_ITEMS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .value         (value),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .rank          (rank),
        .last_rank     (last_rank),
        .overflowed    (overflowed),
        .fail_count    (fail_count),
        .pending       (pending),
        .ranks_checked (ranks_checked)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        in_fire <= in_valid && !in_stall;

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("value_rank_assigner_unit verification failed");
                $finish;
            end
        end
    end

    task automatic send_request(input logic signed [VALUE_W-1:0] v, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        is_last  <= last;
        do
            @(negedge clk);
        while (!in_fire);
        requests_sent++;
    endtask

    task automatic drain_ranks();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0, 1: return $urandom;
            2:    return $urandom_range(0, 15) - 8;
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    2:       return 32'shffff_ffff;
                    default: return 32'sd0;
                endcase
            end
        endcase
    endfunction

    initial
    begin
        int random_sent;
        int set_size;
        int phase;
        int cur_phase;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        value    = '0;
        is_last  = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            send_request(DIRECTED_VALUES[i], DIRECTED_ENDS[i]);
            if (DIRECTED_ENDS[i])
                sets_sent++;
        end
        drain_ranks();

        random_sent = 0;
        cur_phase   = 0;
        while (random_sent < RANDOM_REQUESTS)
        begin
            phase = random_sent * 4 / RANDOM_REQUESTS;
            if (phase != cur_phase)
            begin
                drain_ranks();
                cur_phase = phase;
                case (phase)
                    1:       begin send_idle_pct = 49; stall_pct = 0;  end
                    2:       begin send_idle_pct = 0;  stall_pct = 49; end
                    default: begin send_idle_pct = 8;  stall_pct = 8;  end
                endcase
            end
            if (sets_sent == 4)
                set_size = MAX_ITEMS;
            else if (sets_sent == 5)
                set_size = MAX_ITEMS + 1;
            else if ($urandom_range(0, 15) == 0)
                set_size = $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 6);
            else
                set_size = $urandom_range(1, 12);
            for (int i = 0; i < set_size; i++)
                send_request(pick_value(), i == set_size - 1);
            random_sent += set_size;
            sets_sent++;
            if (set_size > MAX_ITEMS)
                overflow_sets++;
        end

        drain_ranks();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d requests in %0d sets (%0d past the %0d-entry store), %0d ranks",
                 requests_sent, sets_sent, overflow_sets, MAX_ITEMS, ranks_checked);
        $display("Idle mixes: none, sender 49%%, receiver 49%%, both 8%%; ties and extremes");
        if (fail_count == 0 && pending == 0)
            $display("value_rank_assigner_unit verification clean");
        else
            $display("value_rank_assigner_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
